### rtl/core/c8alu_pkg.sv
// shared types and constants of the 8-bit cpu alu and flag unit
package c8alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RL    = 5'd12,
    OP_RR    = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SWAP  = 5'd16,
    OP_SRL   = 5'd17,
    OP_RLCA  = 5'd18,
    OP_RRCA  = 5'd19,
    OP_RLA   = 5'd20,
    OP_RRA   = 5'd21,
    OP_BIT   = 5'd22,
    OP_RES   = 5'd23,
    OP_SET   = 5'd24,
    OP_DAA   = 5'd25,
    OP_CPL   = 5'd26,
    OP_SCF   = 5'd27,
    OP_CCF   = 5'd28,
    OP_ADD16 = 5'd29,
    OP_SPOFS = 5'd30
  } alu_op_t;

  // bit3 z, bit2 n, bit1 h, bit0 c
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HI_LIM  = 8'h99;
  localparam logic [3:0] DAA_LO_LIM  = 4'h9;

endpackage

### rtl/core/c8alu_if.sv
// valid/ready channels of the alu: command word in, result word out
interface c8alu_cmd_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic [7:0]  acc_value;
  logic [7:0]  operand_value;
  logic [2:0]  bit_index;
  logic [3:0]  flags_in;
  logic [15:0] wide_left;
  logic [15:0] wide_right;

  modport source (output valid, op, acc_value, operand_value, bit_index, flags_in,
                  wide_left, wide_right, input ready);
  modport sink (input valid, op, acc_value, operand_value, bit_index, flags_in,
                wide_left, wide_right, output ready);
endinterface

interface c8alu_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic [3:0]  flags_out;
  logic        writes_back;

  modport source (output valid, result, flags_out, writes_back, input ready);
  modport sink (input valid, result, flags_out, writes_back, output ready);
endinterface

### rtl/core/cpu8_alu_with_flags.sv
// alu and flag unit of an 8-bit cpu: operand register, flag logic, result register
//
// usage:
//   cmd carries one operation word: op code, accumulator, second operand, bit
//   number, incoming flags and two 16-bit operands. res returns one word per
//   command: result (8-bit results zero-extended), new flags and writes_back.
//   a taken word is first captured in the operand register; it then goes
//   through the alu logic into the result register, where res.valid rises.
//   throughput is one word per cycle while res.ready stays high; both
//   registers advance together whenever the result register is empty or
//   being taken.
//   when res.ready is low with a word waiting, the pipe holds and cmd.ready
//   drops, so no word is lost; words come out in the order taken.
//   rst (synchronous, active high) empties both stages; payload is kept.
//   the unused op code returns result 0, flags unchanged, no write back.
module cpu8_alu_with_flags
  import c8alu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  c8alu_cmd_if.sink    cmd,
  c8alu_res_if.source  res
);

  logic         advance;
  logic         s1_valid;
  alu_op_t      s1_op;
  logic [7:0]   s1_a;
  logic [7:0]   s1_v;
  logic [2:0]   s1_bi;
  flags_t       s1_f;
  logic [15:0]  s1_wl;
  logic [15:0]  s1_wr;

  logic         out_valid;
  logic [15:0]  out_result;
  flags_t       out_flags;
  logic         out_wb;

  logic [15:0]  result_next;
  flags_t       flags_next;
  logic         wb_next;

  assign advance   = !out_valid || res.ready;
  assign cmd.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op      <= alu_op_t'(cmd.op);
      s1_a       <= cmd.acc_value;
      s1_v       <= cmd.operand_value;
      s1_bi      <= cmd.bit_index;
      s1_f       <= flags_t'(cmd.flags_in);
      s1_wl      <= cmd.wide_left;
      s1_wr      <= cmd.wide_right;
      out_result <= result_next;
      out_flags  <= flags_next;
      out_wb     <= wb_next;
    end
  end

  always_comb begin
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  dif9;
    logic [4:0]  hdif5;
    logic [7:0]  r8;
    logic [7:0]  mask;
    logic [7:0]  x;
    logic        dc;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] ofs16;

    cin   = s1_f.c;
    sum9  = {1'b0, s1_a} + {1'b0, s1_v}
            + {8'd0, (s1_op == OP_ADC) & cin};
    hsum5 = {1'b0, s1_a[3:0]} + {1'b0, s1_v[3:0]}
            + {4'd0, (s1_op == OP_ADC) & cin};
    dif9  = {1'b0, s1_a} - {1'b0, s1_v}
            - {8'd0, (s1_op == OP_SBC) & cin};
    hdif5 = {1'b0, s1_a[3:0]} - {1'b0, s1_v[3:0]}
            - {4'd0, (s1_op == OP_SBC) & cin};
    mask  = 8'd1 << s1_bi;
    sum17 = {1'b0, s1_wl} + {1'b0, s1_wr};
    sum13 = {1'b0, s1_wl[11:0]} + {1'b0, s1_wr[11:0]};
    ofs16 = s1_wl + {{8{s1_v[7]}}, s1_v};

    r8          = 8'd0;
    x           = s1_a;
    dc          = cin;
    result_next = 16'd0;
    flags_next  = s1_f;
    wb_next     = 1'b1;

    case (s1_op)
      OP_ADD, OP_ADC: begin
        r8         = sum9[7:0];
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8         = dif9[7:0];
        flags_next = '{z: (r8 == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
        wb_next    = (s1_op != OP_CP);
      end
      OP_AND: begin
        r8         = s1_a & s1_v;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        r8         = s1_a ^ s1_v;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        r8         = s1_a | s1_v;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        r8         = s1_a + 8'd1;
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: (s1_a[3:0] == 4'hf), c: cin};
      end
      OP_DEC: begin
        r8         = s1_a - 8'd1;
        flags_next = '{z: (r8 == 8'd0), n: 1'b1, h: (s1_a[3:0] == 4'h0), c: cin};
      end
      OP_RLC, OP_RLCA: begin
        r8         = {s1_a[6:0], s1_a[7]};
        flags_next = '{z: (s1_op == OP_RLC) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: s1_a[7]};
      end
      OP_RRC, OP_RRCA: begin
        r8         = {s1_a[0], s1_a[7:1]};
        flags_next = '{z: (s1_op == OP_RRC) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: s1_a[0]};
      end
      OP_RL, OP_RLA: begin
        r8         = {s1_a[6:0], cin};
        flags_next = '{z: (s1_op == OP_RL) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: s1_a[7]};
      end
      OP_RR, OP_RRA: begin
        r8         = {cin, s1_a[7:1]};
        flags_next = '{z: (s1_op == OP_RR) && (r8 == 8'd0), n: 1'b0, h: 1'b0,
                       c: s1_a[0]};
      end
      OP_SLA: begin
        r8         = {s1_a[6:0], 1'b0};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: s1_a[7]};
      end
      OP_SRA: begin
        r8         = {s1_a[7], s1_a[7:1]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: s1_a[0]};
      end
      OP_SWAP: begin
        r8         = {s1_a[3:0], s1_a[7:4]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_SRL: begin
        r8         = {1'b0, s1_a[7:1]};
        flags_next = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: s1_a[0]};
      end
      OP_BIT: begin
        wb_next    = 1'b0;
        flags_next = '{z: ((s1_a & mask) == 8'd0), n: 1'b0, h: 1'b1, c: cin};
      end
      OP_RES: r8 = s1_a & ~mask;
      OP_SET: r8 = s1_a | mask;
      OP_DAA: begin
        // after add: fix high digit first, low digit test uses the original nibble
        if (!s1_f.n) begin
          if (cin || (s1_a > DAA_HI_LIM)) begin
            x  = x + DAA_HI_ADJ;
            dc = 1'b1;
          end
          if (s1_f.h || (s1_a[3:0] > DAA_LO_LIM)) x = x + DAA_LO_ADJ;
        end else begin
          if (cin) x = x - DAA_HI_ADJ;
          if (s1_f.h) x = x - DAA_LO_ADJ;
        end
        r8         = x;
        flags_next = '{z: (r8 == 8'd0), n: s1_f.n, h: 1'b0, c: dc};
      end
      OP_CPL: begin
        r8         = ~s1_a;
        flags_next = '{z: s1_f.z, n: 1'b1, h: 1'b1, c: cin};
      end
      OP_SCF: begin
        wb_next    = 1'b0;
        flags_next = '{z: s1_f.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        wb_next    = 1'b0;
        flags_next = '{z: s1_f.z, n: 1'b0, h: 1'b0, c: !cin};
      end
      default: begin
        wb_next = 1'b0;
      end
    endcase

    result_next = {8'd0, r8};

    // 16-bit forms override the byte path
    if (s1_op == OP_ADD16) begin
      result_next = sum17[15:0];
      flags_next  = '{z: s1_f.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      wb_next     = 1'b1;
    end else if (s1_op == OP_SPOFS) begin
      result_next = ofs16;
      flags_next  = '{z: 1'b0, n: 1'b0,
                      h: ({1'b0, s1_wl[3:0]} + {1'b0, s1_v[3:0]}) > 5'd15,
                      c: ({1'b0, s1_wl[7:0]} + {1'b0, s1_v}) > 9'd255};
      wb_next     = 1'b1;
    end
  end

  assign res.valid       = out_valid;
  assign res.result      = out_result;
  assign res.flags_out   = out_flags;
  assign res.writes_back = out_wb;

endmodule

### rtl/core/c8alu_chk.sv
// port-level checks of the alu, bound to the top level
module c8alu_chk
  import c8alu_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic [4:0]  cmd_op,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_result,
  input logic [3:0]  res_flags_out,
  input logic        res_writes_back
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_result)
      && $stable(res_flags_out) && $stable(res_writes_back))
    else $error("result word changed under stall");

  // an empty output stage never pushes back on commands
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("cmd stalled with empty output");

  // a compare taken and followed by a taking receiver shows up without write back
  a_cp_no_wb: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (cmd_op == OP_CP)) ##1 res_ready
      |=> res_valid && !res_writes_back)
    else $error("compare word missing or marked for write back");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind cpu8_alu_with_flags c8alu_chk u_c8alu_chk (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_op          (cmd.op),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_result      (res.result),
  .res_flags_out   (res.flags_out),
  .res_writes_back (res.writes_back)
);
